### rtl/core/swm_pkg.sv
// Shared definitions for the sliding window median filter.
// Holds sizes, field widths and the structs that run along the cell chain.
// No dependencies.
package swm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SAMPLE_W   = 32;
  localparam int WS_W       = 7;
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

  // What one cell shows its two neighbors.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                gt_new;  // entry sorts after the incoming sample (or is empty)
    logic                ge_old;  // entry sits at or after the departing sample
  } link_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic                load;
    logic                remove;
    logic [SAMPLE_W-1:0] new_value;
    logic [SAMPLE_W-1:0] old_value;
  } bcast_t;

endpackage

### rtl/core/sliding_window_median.sv
// Top level of the sliding window median filter.
// Depends on swm_pkg, swm_cell and swm_history.
//
// Usage. Samples arrive on the s_ stream: s_tdata carries the signed 32-bit
// sample and s_tuser the first flag, which empties the window before that
// sample enters. Once window_size samples of the current sequence have been
// seen, each further request yields the lower median of the last window_size
// samples on the m_ stream; earlier requests yield nothing. window_size is
// clamped to 1..64 and a write to it also starts a fresh sequence; the user
// has to see that it is written only while the filter is idle, which the
// block does not enforce. Throughput is one request per cycle while the
// output is not stalled. The sorted window lives in a chain of 64
// compare-and-shift cells that takes out the departing sample and puts in
// the new one in the same cycle; the departing sample is read ahead from
// the history ring. An accepted request reaches m_tdata through the cell
// update, then the pick of the median cell into the output register.
// Reset returns window_size to 3 and empties the window. When the receiver
// stalls, the output register holds its result and one more result may wait
// in the cells; the input then stops taking requests until that clears.
module sliding_window_median (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         window_size_we,
  input  logic [swm_pkg::WS_W-1:0]     window_size,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [swm_pkg::SAMPLE_W-1:0] s_tdata,   // [31:0] sample
  input  logic [0:0]                   s_tuser,   // [0] first
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [swm_pkg::SAMPLE_W-1:0] m_tdata    // [31:0] median
);

  localparam int N = swm_pkg::MAX_WINDOW;

  // Configuration and sequence state.
  logic [swm_pkg::WS_W-1:0]   ws_reg;
  logic [swm_pkg::SLOT_W-1:0] slot;
  logic [swm_pkg::CNT_W-1:0]  fill;
  logic                       res_pend;
  logic [swm_pkg::SAMPLE_W-1:0] out_data;
  logic                       out_valid;

  // Effective window size and the ascending index of the lower median.
  logic [swm_pkg::CNT_W-1:0]  k;
  logic [swm_pkg::CNT_W-1:0]  k_minus1;
  logic [swm_pkg::SLOT_W-1:0] mid;

  always_comb begin
    if (ws_reg == '0) begin
      k = swm_pkg::CNT_W'(1);
    end else if (int'(ws_reg) > N) begin
      k = swm_pkg::CNT_W'(N);
    end else begin
      k = swm_pkg::CNT_W'(ws_reg);
    end
    k_minus1 = k - swm_pkg::CNT_W'(1);
    mid      = swm_pkg::SLOT_W'(k_minus1 >> 1);
  end

  // Handshake. A request may enter unless a finished result is still in the
  // cells and the output register cannot give way to it.
  logic accept;
  logic drain;
  assign drain    = !out_valid || m_tready;
  assign s_tready = !res_pend || drain;
  assign accept   = s_tvalid && s_tready;

  // Sequence bookkeeping for the request on the input.
  logic                       first;
  logic [swm_pkg::CNT_W-1:0]  n_cur;
  logic [swm_pkg::SLOT_W-1:0] slot_cur;
  logic [swm_pkg::SLOT_W-1:0] slot_after;
  logic                       remove;
  logic [swm_pkg::CNT_W-1:0]  n_new;
  logic [swm_pkg::SLOT_W-1:0] rd_addr;

  always_comb begin
    first    = s_tuser[0];
    n_cur    = first ? '0 : fill;
    slot_cur = first ? '0 : slot;
    remove   = (n_cur == k);
    n_new    = remove ? n_cur : n_cur + swm_pkg::CNT_W'(1);
    if ((swm_pkg::CNT_W'(slot_cur) + swm_pkg::CNT_W'(1)) == k) begin
      slot_after = '0;
    end else begin
      slot_after = slot_cur + swm_pkg::SLOT_W'(1);
    end
    // Read ahead the slot the next request will overwrite.
    if (window_size_we) begin
      rd_addr = '0;
    end else if (accept) begin
      rd_addr = slot_after;
    end else begin
      rd_addr = slot;
    end
  end

  logic [swm_pkg::SAMPLE_W-1:0] old_value;

  swm_history u_history (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (slot_cur),
    .wr_data (s_tdata),
    .rd_addr (rd_addr),
    .rd_data (old_value)
  );

  // The cell chain.
  swm_pkg::bcast_t bc;
  swm_pkg::link_t  links [N];
  swm_pkg::link_t  edge_lo;
  swm_pkg::link_t  edge_hi;

  always_comb begin
    bc.load      = accept;
    bc.remove    = remove;
    bc.new_value = s_tdata;
    bc.old_value = old_value;
    // Below the chain nothing sorts after the sample; above it, everything.
    edge_lo      = '{value: '0, gt_new: 1'b0, ge_old: 1'b0};
    edge_hi      = '{value: '0, gt_new: 1'b1, ge_old: 1'b0};
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic cell_valid;
    assign cell_valid = (n_cur > swm_pkg::CNT_W'(i));
    swm_cell u_cell (
      .clk   (clk),
      .bc    (bc),
      .valid (cell_valid),
      .left  ((i == 0)     ? edge_lo : links[(i == 0) ? 0 : i - 1]),
      .right ((i == N - 1) ? edge_hi : links[(i == N - 1) ? i : i + 1]),
      .self  (links[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ws_reg    <= swm_pkg::WS_RESET;
      slot      <= '0;
      fill      <= '0;
      res_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (window_size_we) begin
        ws_reg <= window_size;
        slot   <= '0;
        fill   <= '0;
      end else if (accept) begin
        slot <= slot_after;
        fill <= n_new;
      end
      if (accept) begin
        res_pend <= (n_new >= k);
      end else if (drain) begin
        res_pend <= 1'b0;
      end
      if (res_pend && drain) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register: the median cell, taken after the update once the output can give way.
  always_ff @(posedge clk) begin
    if (res_pend && drain) begin
      out_data <= links[mid].value;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### rtl/core/swm_cell.sv
// One entry of the sorted window, with its compare and shift logic.
// Depends on swm_pkg.
module swm_cell (
  input  logic           clk,
  input  swm_pkg::bcast_t bc,
  input  logic           valid,
  input  swm_pkg::link_t left,
  input  swm_pkg::link_t right,
  output swm_pkg::link_t self
);

  logic [swm_pkg::SAMPLE_W-1:0] value;
  logic [swm_pkg::SAMPLE_W-1:0] value_next;
  logic [swm_pkg::SAMPLE_W-1:0] here_val;
  logic [swm_pkg::SAMPLE_W-1:0] prev_val;
  logic                         here_gt;
  logic                         prev_gt;

  always_comb begin
    self.value  = value;
    self.gt_new = !valid || ($signed(value) > $signed(bc.new_value));
    self.ge_old = bc.remove && valid && ($signed(value) >= $signed(bc.old_value));
  end

  // The list with the departing entry taken out, seen at this place and the one before.
  always_comb begin
    here_val = self.ge_old ? right.value  : value;
    here_gt  = self.ge_old ? right.gt_new : self.gt_new;
    prev_val = left.ge_old ? value        : left.value;
    prev_gt  = left.ge_old ? self.gt_new  : left.gt_new;
    if (prev_gt) begin
      value_next = prev_val;
    end else if (here_gt) begin
      value_next = bc.new_value;
    end else begin
      value_next = here_val;
    end
  end

  always_ff @(posedge clk) begin
    if (bc.load) begin
      value <= value_next;
    end
  end

endmodule

### rtl/core/swm_history.sv
// Arrival-order ring of samples; presents the sample about to leave the window.
// Depends on swm_pkg.
module swm_history (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [swm_pkg::SLOT_W-1:0]   wr_addr,
  input  logic [swm_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [swm_pkg::SLOT_W-1:0]   rd_addr,
  output logic [swm_pkg::SAMPLE_W-1:0] rd_data
);

  logic [swm_pkg::SAMPLE_W-1:0] ring [swm_pkg::MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same slot is passed straight through.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= ring[rd_addr];
    end
  end

endmodule

### rtl/core/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to its top.
// Depends on swm_pkg and sliding_window_median.
module swm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [swm_pkg::SAMPLE_W-1:0] m_tdata
);

  // A stalled result stays offered.
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // A result only appears after a request was taken.
  a_rise_cause : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching request");

  // Reset leaves the output empty and the input open.
  a_reset_out : assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output or input wrong after reset");

  // The input only closes while a result waits at a stalled output.
  a_ready_cause : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input closed without a stalled output");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
